[src/star_region_labeler_defines.svh]
// ---------------------------------------------------------------------------
// star_region_labeler_defines
// assertion macros for the labeller rtl, used by slbl_back
// ---------------------------------------------------------------------------
`ifndef STAR_REGION_LABELER_DEFINES_SVH
`define STAR_REGION_LABELER_DEFINES_SVH

// clocked assertion, switched off while reset is asserted
`define SRL_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, on the usual clock and reset names
`define SRL_ASSERT(name, prop, msg) `SRL_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

[src/slbl_pkg.sv]
// ---------------------------------------------------------------------------
// slbl_pkg
// shared types and constants of the star region labeller
// ---------------------------------------------------------------------------
`default_nettype none

package slbl_pkg;

  // configuration register width and reset geometry
  localparam int unsigned CFG_W          = 11;
  localparam logic [CFG_W-1:0] CFG_GEOM_RESET = 11'd1024;
  localparam int unsigned CFG_IDX_W      = 2;

  // width for geometry compares, holds any size up to 4096
  localparam int unsigned GEOM_W  = 13;
  // coordinate width carried between front and back
  localparam int unsigned COORD_W = 12;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_COLUMNS = 2'd0,
    CFG_IMAGE_ROWS    = 2'd1
  } cfg_index_e;

  // per pixel classification from the front
  typedef struct packed {
    logic bright;
    logic first_row;
    logic first_col;
    logic above_ok;
    logic frame_last;
  } px_flags_t;

  // one pixel on its way to the back
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] rd_addr;
    px_flags_t          flags;
  } px_item_t;

endpackage

`default_nettype wire

[src/slbl_front.sv]
// ---------------------------------------------------------------------------
// slbl_front
// takes pixel beats, tracks the scan position and classifies each pixel
// ---------------------------------------------------------------------------
`default_nettype none

module slbl_front #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [slbl_pkg::CFG_W-1:0]  cols_cfg_i,
  input  wire logic [slbl_pkg::CFG_W-1:0]  rows_cfg_i,
  input  wire logic                        in_valid_i,
  input  wire logic                        bright_i,
  output logic                             in_stall_o,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output slbl_pkg::px_item_t               item_o
);
  import slbl_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLUMNS);

  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [GEOM_W-1:0] rows_eff, cols_eff;
  logic [GEOM_W-1:0] row_next, col_next;
  logic              last_row, last_col;

  // clamp geometry: zero reads as one, oversize reads as the maximum
  always_comb begin
    if (rows_cfg_i == '0) begin
      rows_eff = GEOM_W'(1);
    end else if (GEOM_W'(rows_cfg_i) > GEOM_W'(MAX_ROWS)) begin
      rows_eff = GEOM_W'(MAX_ROWS);
    end else begin
      rows_eff = GEOM_W'(rows_cfg_i);
    end
    if (cols_cfg_i == '0) begin
      cols_eff = GEOM_W'(1);
    end else if (GEOM_W'(cols_cfg_i) > GEOM_W'(MAX_COLUMNS)) begin
      cols_eff = GEOM_W'(MAX_COLUMNS);
    end else begin
      cols_eff = GEOM_W'(cols_cfg_i);
    end
  end

  // end of column and end of frame
  assign row_next = GEOM_W'(row_q) + GEOM_W'(1);
  assign col_next = GEOM_W'(col_q) + GEOM_W'(1);
  assign last_row = (row_next >= rows_eff);
  assign last_col = (col_next >= cols_eff);

  // handshake towards the queue
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classified pixel; the last row reads entry 0 ahead of the next column
  always_comb begin
    item_o                  = '0;
    item_o.col              = COORD_W'(col_q);
    item_o.row              = COORD_W'(row_q);
    item_o.rd_addr          = last_row ? '0 : COORD_W'(row_next);
    item_o.flags.bright     = bright_i;
    item_o.flags.first_row  = (row_q == '0);
    item_o.flags.first_col  = (col_q == '0);
    item_o.flags.above_ok   = !last_row;
    item_o.flags.frame_last = last_row && last_col;
  end

  // scan position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (last_row) begin
        row_d = '0;
        col_d = last_col ? '0 : col_q + CW'(1);
      end else begin
        row_d = row_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

`default_nettype wire

[src/slbl_fifo.sv]
// ---------------------------------------------------------------------------
// slbl_fifo
// short queue of classified pixels between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module slbl_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire slbl_pkg::px_item_t  item_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output slbl_pkg::px_item_t       item_o
);
  import slbl_pkg::*;

  px_item_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

[src/slbl_back.sv]
// ---------------------------------------------------------------------------
// slbl_back
// reads the previous column store, picks or issues the label, drives results
// ---------------------------------------------------------------------------
`default_nettype none
`include "star_region_labeler_defines.svh"

module slbl_back #(
  parameter int unsigned MAX_ROWS   = 1024,
  parameter int unsigned MAX_LABELS = 4095
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire slbl_pkg::px_item_t  q_item_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [9:0]               column_o,
  output logic [9:0]               row_o,
  output logic [11:0]              star_label_o,
  output logic                     new_star_o,
  output logic                     frame_end_o,
  output logic [11:0]              star_count_o,
  output logic                     label_overflow_o
);
  import slbl_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned LW = $clog2(MAX_LABELS + 1);

  // previous column labels, indexed by row
  logic [LW-1:0] label_mem [MAX_ROWS];

  // labelling stage
  logic          b_valid_q;
  px_item_t      b_q;
  logic [LW-1:0] rd_q;
  logic          byp_hit_q;
  logic [LW-1:0] byp_data_q;

  // scan context
  logic [LW-1:0] below_q, here_q, diag_q;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;

  // output register
  logic          out_valid_q;
  logic [9:0]    column_q, row_q;
  logic [11:0]   star_label_q, star_count_q;
  logic          new_star_q, frame_end_q, ovf_out_q;

  logic          en, leave;
  logic [LW-1:0] rd_eff, old_above, lbl;
  logic          fresh;

  // whole back advances when the output register is free
  assign en    = !out_valid_q || !out_stall_i;
  assign leave = en && b_valid_q;
  assign pop_o = en && q_valid_i;

  // store read, with the label written at the same edge forwarded
  assign rd_eff    = byp_hit_q ? byp_data_q : rd_q;
  assign old_above = b_q.flags.above_ok ? rd_eff : '0;

  // neighbour priority: below, row plus one, same row, row minus one
  always_comb begin
    lbl   = '0;
    fresh = 1'b0;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (b_q.flags.bright) begin
      if (!b_q.flags.first_row && below_q != '0) begin
        lbl = below_q;
      end else if (!b_q.flags.first_col && old_above != '0) begin
        lbl = old_above;
      end else if (!b_q.flags.first_col && here_q != '0) begin
        lbl = here_q;
      end else if (!b_q.flags.first_col && !b_q.flags.first_row && diag_q != '0) begin
        lbl = diag_q;
      end else if (cnt_q < LW'(MAX_LABELS)) begin
        cnt_d = cnt_q + LW'(1);
        lbl   = cnt_d;
        fresh = 1'b1;
      end else begin
        ovf_d = 1'b1;
        lbl   = LW'(MAX_LABELS);
      end
    end
  end

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (leave) begin
      label_mem[b_q.row[RW-1:0]] <= lbl;
    end
    if (en) begin
      rd_q <= label_mem[q_item_i.rd_addr[RW-1:0]];
    end
  end

  // stage payload and forwarding data
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q        <= q_item_i;
      byp_data_q <= lbl;
    end
  end

  // stage control and scan context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      byp_hit_q <= 1'b0;
      below_q   <= '0;
      here_q    <= '0;
      diag_q    <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (en) begin
        b_valid_q <= q_valid_i;
        byp_hit_q <= b_valid_q && (b_q.row[RW-1:0] == q_item_i.rd_addr[RW-1:0]);
      end
      if (leave) begin
        below_q <= lbl;
        // one row per column: this pixel is the next one's same row neighbour
        here_q  <= (b_q.flags.first_row && !b_q.flags.above_ok) ? lbl : rd_eff;
        diag_q  <= here_q;
        cnt_q   <= b_q.flags.frame_last ? '0 : cnt_d;
        ovf_q   <= b_q.flags.frame_last ? 1'b0 : ovf_d;
      end
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (leave) begin
      column_q     <= 10'(b_q.col);
      row_q        <= 10'(b_q.row);
      star_label_q <= 12'(lbl);
      new_star_q   <= fresh;
      frame_end_q  <= b_q.flags.frame_last;
      star_count_q <= 12'(cnt_d);
      ovf_out_q    <= ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign column_o         = column_q;
  assign row_o            = row_q;
  assign star_label_o     = star_label_q;
  assign new_star_o       = new_star_q;
  assign frame_end_o      = frame_end_q;
  assign star_count_o     = star_count_q;
  assign label_overflow_o = ovf_out_q;

  // checks
  `SRL_ASSERT(a_fresh_matches_count, out_valid_q && new_star_q |-> star_label_q == star_count_q, "new label differs from label count")
  `SRL_ASSERT(a_overflow_saturated, ovf_q |-> cnt_q == LW'(MAX_LABELS), "overflow set below saturation")
  `SRL_ASSERT(a_frame_end_clears, leave && b_q.flags.frame_last |=> cnt_q == '0 && !ovf_q, "frame end left label state")

endmodule

`default_nettype wire

[src/star_region_labeler.sv]
// ---------------------------------------------------------------------------
// star_region_labeler
// single pass 8-neighbour star region labeller over a column-major scan
// ---------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid_i/in_stall_o   bright_i
//  out       output     out_valid_o/out_stall_i column, row, label, flags, count
//  cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  one pixel per clock sustained while the output is not stalled; a pixel beat
//  written into the queue passes the label stage and then the output register.
//  the label stage does one store read and one store write per cycle.
//  reset clears the scan position and label state; the row store is not
//  cleared and needs no pass.
//  a stalled output holds the back; the two entry queue keeps taking pixels
//  until it fills.
// ---------------------------------------------------------------------------
`default_nettype none

module star_region_labeler #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_LABELS  = 4095
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [slbl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [slbl_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           bright_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [9:0]                          column_o,
  output logic [9:0]                          row_o,
  output logic [11:0]                         star_label_o,
  output logic                                new_star_o,
  output logic                                frame_end_o,
  output logic [11:0]                         star_count_o,
  output logic                                label_overflow_o
);
  import slbl_pkg::*;

  logic [CFG_W-1:0] columns_q, rows_q;
  logic             push, q_full, q_valid, pop;
  px_item_t         push_item, head_item;

  // geometry registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= CFG_GEOM_RESET;
      rows_q    <= CFG_GEOM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IMAGE_COLUMNS: columns_q <= cfg_data_i;
        CFG_IMAGE_ROWS:    rows_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // front: scan position and classification
  slbl_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cols_cfg_i (columns_q),
    .rows_cfg_i (rows_q),
    .in_valid_i (in_valid_i),
    .bright_i   (bright_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // queue between the halves
  slbl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // back: labelling and result beats
  slbl_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_LABELS (MAX_LABELS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .column_o         (column_o),
    .row_o            (row_o),
    .star_label_o     (star_label_o),
    .new_star_o       (new_star_o),
    .frame_end_o      (frame_end_o),
    .star_count_o     (star_count_o),
    .label_overflow_o (label_overflow_o)
  );

endmodule

`default_nettype wire

[tb/sv/tb_star_region_labeler.sv]
// ---------------------------------------------------------------------------
// tb_star_region_labeler
// self-checking bench for the column-major star region labeller
// ---------------------------------------------------------------------------
//  pixels go in as single beats with random gaps and leave as result beats
//  under random output stalls. a behavioural labeller inside the bench
//  predicts every result beat, which is compared field by field in order.
//  the tests cover neighbour priority, geometry extremes, a long output
//  hold-off, geometry changes within a frame and a run of random frames.
// ---------------------------------------------------------------------------

module tb_star_region_labeler;
  timeunit 1ns;
  timeprecision 1ps;

  import slbl_pkg::*;

  localparam int unsigned ROWS_LIMIT      = 1024;
  localparam int unsigned COLS_LIMIT      = 1024;
  localparam int unsigned LABELS_LIMIT    = 4095;
  localparam int unsigned RANDOM_PIXELS   = 450;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS     = 40;

  // one expected result beat
  typedef struct packed {
    logic [9:0]  column;
    logic [9:0]  row;
    logic [11:0] star_label;
    logic        new_star;
    logic        frame_end;
    logic [11:0] star_count;
    logic        label_overflow;
  } pixel_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             bright_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [9:0]       column_o;
  logic [9:0]       row_o;
  logic [11:0]      star_label_o;
  logic             new_star_o;
  logic             frame_end_o;
  logic [11:0]      star_count_o;
  logic             label_overflow_o;

  star_region_labeler #(
    .MAX_ROWS    (ROWS_LIMIT),
    .MAX_COLUMNS (COLS_LIMIT),
    .MAX_LABELS  (LABELS_LIMIT)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .bright_i         (bright_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .column_o         (column_o),
    .row_o            (row_o),
    .star_label_o     (star_label_o),
    .new_star_o       (new_star_o),
    .frame_end_o      (frame_end_o),
    .star_count_o     (star_count_o),
    .label_overflow_o (label_overflow_o)
  );

  // labeller state mirrored by the bench
  logic [11:0]      prior_column_labels [ROWS_LIMIT];
  logic [11:0]      lower_label;
  logic [11:0]      corner_label;
  int unsigned      scan_col;
  int unsigned      scan_row;
  int unsigned      labels_issued;
  logic             labels_saturated;
  logic [CFG_W-1:0] geom_cols;
  logic [CFG_W-1:0] geom_rows;

  pixel_result_t    labelled_pixels [$];

  int unsigned      fail_count;
  int unsigned      pixels_sent;
  int unsigned      results_checked;
  int unsigned      frames_done;
  int unsigned      overflow_pixels;

  logic             offering;
  logic             burst_mode;
  logic             last_frame_end;
  logic             hold_off_request;

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // mostly short idles, now and then a long one
  function automatic int unsigned pick_idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // register value to effective size
  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] value,
                                             input int unsigned limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  // label one pixel and advance the scan position
  function automatic pixel_result_t label_pixel(input logic bright);
    int unsigned   rows_n;
    int unsigned   cols_n;
    int unsigned   r;
    int unsigned   c;
    logic          above_ok;
    logic [11:0]   here_lbl;
    logic [11:0]   above_lbl;
    logic [11:0]   lbl;
    pixel_result_t res;
    rows_n    = clamp_size(geom_rows, ROWS_LIMIT);
    cols_n    = clamp_size(geom_cols, COLS_LIMIT);
    r         = scan_row;
    c         = scan_col;
    above_ok  = (r + 1 < rows_n) && (r + 1 < ROWS_LIMIT);
    here_lbl  = (r < ROWS_LIMIT) ? prior_column_labels[r] : '0;
    above_lbl = above_ok ? prior_column_labels[r + 1] : '0;
    lbl       = '0;
    res       = '0;
    // neighbour priority: below, then previous column at row+1, row, row-1
    if (bright) begin
      if (r > 0 && lower_label != 0) begin
        lbl = lower_label;
      end else if (c > 0 && above_ok && above_lbl != 0) begin
        lbl = above_lbl;
      end else if (c > 0 && here_lbl != 0) begin
        lbl = here_lbl;
      end else if (c > 0 && r > 0 && corner_label != 0) begin
        lbl = corner_label;
      end else if (labels_issued < LABELS_LIMIT) begin
        labels_issued++;
        lbl = 12'(labels_issued);
        res.new_star = 1'b1;
      end else begin
        labels_saturated = 1'b1;
        lbl = 12'(LABELS_LIMIT);
        overflow_pixels++;
      end
    end
    corner_label = here_lbl;
    if (r < ROWS_LIMIT) prior_column_labels[r] = lbl;
    lower_label = lbl;
    // scan position, wrapping at or beyond the last index
    if (r + 1 >= rows_n) begin
      scan_row     = 0;
      corner_label = '0;
      if (c + 1 >= cols_n) begin
        scan_col      = 0;
        res.frame_end = 1'b1;
      end else begin
        scan_col = c + 1;
      end
    end else begin
      scan_row = r + 1;
    end
    res.column         = 10'(c);
    res.row            = 10'(r);
    res.star_label     = lbl;
    res.star_count     = 12'(labels_issued);
    res.label_overflow = labels_saturated;
    if (res.frame_end) begin
      labels_issued    = 0;
      labels_saturated = 1'b0;
      lower_label      = '0;
      frames_done++;
    end
    return res;
  endfunction

  // one pixel beat, with a random gap in front unless bursting
  task automatic send_pixel(input logic bright);
    int unsigned   gap;
    pixel_result_t res;
    gap = burst_mode ? 0 : ($urandom_range(0, 1) ? 0 : pick_idle_len());
    if (gap > 0) begin
      if (offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    bright_i   <= bright;
    offering = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = label_pixel(bright);
    labelled_pixels = {labelled_pixels, res};
    pixels_sent++;
    last_frame_end = res.frame_end;
  endtask

  // finish the current frame with pixels of the given density
  task automatic send_frame_rest(input int unsigned density);
    do begin
      send_pixel($urandom_range(0, 99) < density);
    end while (!last_frame_end);
  endtask

  // stop offering and wait until every result has come back
  task automatic drain_results();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk_i); while (labelled_pixels.size() != 0);
  endtask

  // write both geometry registers while the block is idle
  task automatic reconfigure(input int unsigned cols, input int unsigned rows);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IMAGE_COLUMNS;
    cfg_data_i  <= CFG_W'(cols);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    geom_cols = CFG_W'(cols);
    cfg_index_i <= CFG_IMAGE_ROWS;
    cfg_data_i  <= CFG_W'(rows);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    geom_rows = CFG_W'(rows);
    cfg_valid_i <= 1'b0;
  endtask

  // each neighbour in turn decides the label, plus a single row and 1x1 frame
  task automatic check_neighbour_priority();
    logic [19:0] pattern;
    pattern = 20'b11001_01101_10010_01001;
    reconfigure(4, 5);
    for (int i = 0; i < 20; i++) send_pixel(pattern[i]);
    reconfigure(3, 1);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    // zero registers mean one column and one row
    reconfigure(0, 0);
    send_pixel(1'b1);
  endtask

  // oversize and zero registers: a wide single row, then a tall single column
  task automatic check_geometry_extremes();
    reconfigure(2047, 0);
    repeat (40) send_pixel($urandom_range(0, 99) < 50);
    // one column left: the frame closes after the next pixel
    reconfigure(1, 0);
    send_frame_rest(50);
    reconfigure(0, 2047);
    repeat (40) send_pixel($urandom_range(0, 99) < 50);
    // one row left: the column and the frame close after the next pixel
    reconfigure(0, 1);
    send_frame_rest(50);
  endtask

  // long output hold-off while pixels keep coming, then a full pause
  task automatic check_backpressure();
    reconfigure(8, 8);
    hold_off_request <= 1'b1;
    burst_mode = 1'b1;
    repeat (30) send_pixel($urandom_range(0, 1));
    burst_mode = 1'b0;
    drain_results();
    send_frame_rest(50);
  endtask

  // geometry rewritten part way through frames
  task automatic check_midframe_geometry();
    reconfigure(6, 6);
    repeat (3) send_pixel($urandom_range(0, 1));
    // fewer rows than the current row: wraps after the next pixel
    reconfigure(6, 2);
    repeat (3) send_pixel($urandom_range(0, 1));
    // fewer columns than the current column: frame ends with this column
    reconfigure(2, 2);
    send_frame_rest(60);
    // more rows while still in the first column
    reconfigure(3, 3);
    repeat (2) send_pixel($urandom_range(0, 1));
    reconfigure(3, 5);
    send_frame_rest(60);
  endtask

  // random frames, mostly small, some with a rewrite in the first column
  task automatic check_random_frames();
    int unsigned first;
    int unsigned pick;
    int unsigned cols;
    int unsigned rows;
    int unsigned density;
    first = pixels_sent;
    while (pixels_sent - first < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        cols = $urandom_range(1, 8);
        rows = $urandom_range(1, 8);
      end else if (pick < 92) begin
        cols = $urandom_range(1, 12);
        rows = $urandom_range(9, 40);
      end else begin
        cols = $urandom_range(0, 3);
        rows = $urandom_range(0, 3);
      end
      case ($urandom_range(0, 4))
        0:       density = 10;
        1:       density = 30;
        2:       density = 50;
        3:       density = 70;
        default: density = 95;
      endcase
      reconfigure(cols, rows);
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0 && clamp_size(geom_rows, ROWS_LIMIT) > 1) begin
        repeat ($urandom_range(1, clamp_size(geom_rows, ROWS_LIMIT) - 1)) begin
          send_pixel($urandom_range(0, 99) < density);
        end
        reconfigure($urandom_range(1, 8), $urandom_range(1, 8));
      end
      send_frame_rest(density);
    end
    burst_mode = 1'b0;
  endtask

  // output stall: random runs, free stretches, and the long hold-off
  initial begin
    int unsigned busy;
    int unsigned free;
    busy = 0;
    free = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request <= 1'b0;
        out_stall_i      <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (busy > 0) begin
        out_stall_i <= 1'b1;
        busy--;
      end else if (free > 0) begin
        out_stall_i <= 1'b0;
        free--;
      end else begin
        out_stall_i <= 1'b0;
        free = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 200)
                                            : $urandom_range(0, 12);
        busy = pick_idle_len();
      end
    end
  end

  // one field of a result beat
  task automatic flag_field(input string field, input logic [11:0] want,
                            input logic [11:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      end
    end
  endtask

  // result beats against the oldest expectation
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (labelled_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $error("result beat with nothing expected: column %0d row %0d", column_o, row_o);
        end
      end else begin
        want = labelled_pixels.pop_front();
        results_checked++;
        flag_field("column", 12'(want.column), 12'(column_o));
        flag_field("row", 12'(want.row), 12'(row_o));
        flag_field("star_label", want.star_label, star_label_o);
        flag_field("new_star", 12'(want.new_star), 12'(new_star_o));
        flag_field("frame_end", 12'(want.frame_end), 12'(frame_end_o));
        flag_field("star_count", want.star_count, star_count_o);
        flag_field("label_overflow", 12'(want.label_overflow), 12'(label_overflow_o));
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // reset, then the tests in turn
  initial begin
    rst_ni           <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= CFG_IMAGE_COLUMNS;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    bright_i         <= 1'b0;
    hold_off_request <= 1'b0;
    for (int i = 0; i < ROWS_LIMIT; i++) prior_column_labels[i] = '0;
    lower_label      = '0;
    corner_label     = '0;
    scan_col         = 0;
    scan_row         = 0;
    labels_issued    = 0;
    labels_saturated = 1'b0;
    geom_cols        = CFG_GEOM_RESET;
    geom_rows        = CFG_GEOM_RESET;
    fail_count       = 0;
    pixels_sent      = 0;
    results_checked  = 0;
    frames_done      = 0;
    overflow_pixels  = 0;
    offering         = 1'b0;
    burst_mode       = 1'b0;
    last_frame_end   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    check_neighbour_priority();
    check_geometry_extremes();
    check_backpressure();
    check_midframe_geometry();
    check_random_frames();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run covered %0d frames: %0d pixels sent, %0d results checked",
             frames_done, pixels_sent, results_checked);
    $display("label overflow hit on %0d pixels, %0d mismatches",
             overflow_pixels, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/slbl_pkg.sv
src/slbl_front.sv
src/slbl_fifo.sv
src/slbl_back.sv
src/star_region_labeler.sv
tb/sv/tb_star_region_labeler.sv
